### hdl/unread_range_set_macros.svh
// Assertion macros for the unread range set checker.
// Used by urs_chk.sv only.
`ifndef UNREAD_RANGE_SET_MACROS_SVH
`define UNREAD_RANGE_SET_MACROS_SVH
// Antecedent implies consequent in the same cycle.
`define URS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("unread_range_set check failed");
// Antecedent implies consequent in the next cycle.
`define URS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("unread_range_set check failed");
`endif

### hdl/urs_pkg.sv
// Package for the unread range set: transfer structs, codes and sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package urs_pkg;
    localparam int NB         = 31;
    localparam int MAX_RANGES = 64;
    localparam int AW         = 6;
    localparam int CW         = 7;

    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_UNREAD = 2'd1;
    localparam logic [1:0] OP_APPEND = 2'd2;
    localparam logic [1:0] OP_TRIM   = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_SAME = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_BAD  = 2'd3;

    localparam logic [1:0] REG_LOW  = 2'd0;
    localparam logic [1:0] REG_HIGH = 2'd1;

    typedef struct packed {
        logic [1:0]    opcode;
        logic [NB-1:0] article;
        logic [NB-1:0] range_end;
    } urs_in_t;

    typedef struct packed {
        logic [1:0]    status;
        logic [31:0]   unread_count;
        logic [CW-1:0] ranges_used;
    } urs_out_t;

    typedef struct packed {
        logic [NB-1:0] s;
        logic [NB-1:0] e;
    } urs_range_t;
endpackage
`default_nettype wire

### hdl/unread_range_set.sv
// Unread range set: sequencer with range table held in urs_ram.
// Depends on urs_pkg and urs_ram.
//
// Usage: raise start with cmd while busy is low; the command transfers on
// that edge and busy rises. When the operation ends, done pulses for one
// cycle with result valid, and busy is low again from that cycle, so the
// next command may transfer at the edge that ends the done cycle.
// The receiver cannot stall; result must be taken in the done cycle.
// Configuration: cfg_we with cfg_index 0 (lowest) or 1 (highest) and
// cfg_data, only while busy is low; other indexes are ignored.
// Sequence: mark read and mark unread scan one range at a time up to the
// hit, decode, then shift the ranges behind it one at a time, then write
// and give the result; scan and shift together pass each held range at
// most once. Append reads only the last range before decode and writes,
// writes at once on an empty table, and ends at once when inverted. Trim
// reads each held range once and writes back the clipped ones. The single
// RAM read port makes every pass go one range at a time.
// Reset empties the set (count and total to zero) and zeroes both bounds;
// the table itself needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module unread_range_set (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire urs_pkg::urs_in_t  cmd,
    output logic                   done,
    output urs_pkg::urs_out_t      result,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [urs_pkg::NB-1:0] cfg_data
);
    import urs_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRD  = 4'd1;
    localparam logic [3:0] S_SEV  = 4'd2;
    localparam logic [3:0] S_DEC  = 4'd3;
    localparam logic [3:0] S_UPR  = 4'd4;
    localparam logic [3:0] S_UPW  = 4'd5;
    localparam logic [3:0] S_DNR  = 4'd6;
    localparam logic [3:0] S_DNW  = 4'd7;
    localparam logic [3:0] S_W1   = 4'd8;
    localparam logic [3:0] S_W2   = 4'd9;
    localparam logic [3:0] S_TRD  = 4'd10;
    localparam logic [3:0] S_TEV  = 4'd11;
    localparam logic [3:0] S_FIN  = 4'd12;

    logic [3:0]    state_reg, state_next;
    logic [NB-1:0] low_reg, low_next, high_reg, high_next;
    logic [CW-1:0] total_reg, total_next;
    logic [31:0]   unread_reg, unread_next;
    logic          done_reg, done_next;

    logic [1:0]    op_reg, op_next;
    logic [NB-1:0] n_reg, n_next, l_reg, l_next;
    logic [CW-1:0] idx_reg, idx_next, w_reg, w_next, k_reg, k_next, pos_reg, pos_next;
    logic [31:0]   sum_reg, sum_next;
    logic          found_reg, found_next;
    urs_range_t    cur_reg, cur_next, prev_reg, prev_next;
    logic          w1v_reg, w1v_next, w2v_reg, w2v_next;
    logic [AW-1:0] w1a_reg, w1a_next, w2a_reg, w2a_next;
    urs_range_t    w1d_reg, w1d_next, w2d_reg, w2d_next;
    logic [CW-1:0] ntot_reg, ntot_next;
    logic [31:0]   nunr_reg, nunr_next;
    logic [1:0]    st_reg, st_next;
    urs_out_t      res_reg, res_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    urs_range_t    ram_wdata, ram_rdata;

    logic [31:0]   n_ext, n_inc, prev_inc, cur_inc, span;
    logic          left, right;
    urs_range_t    clip;

    urs_ram #(
        .WIDTH ($bits(urs_range_t)),
        .DEPTH (MAX_RANGES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign n_ext    = {1'b0, n_reg};
    assign n_inc    = n_ext + 32'd1;
    assign prev_inc = {1'b0, prev_reg.e} + 32'd1;
    assign cur_inc  = {1'b0, cur_reg.e} + 32'd1;
    assign left     = (idx_reg != '0) && (prev_inc == n_ext);
    assign right    = found_reg && ({1'b0, cur_reg.s} == n_inc);
    assign clip.s   = (ram_rdata.s < low_reg) ? low_reg : ram_rdata.s;
    assign clip.e   = (ram_rdata.e > high_reg) ? high_reg : ram_rdata.e;
    assign span     = {1'b0, l_reg} - n_ext + 32'd1;

    always_comb
    begin
        state_next  = state_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        total_next  = total_reg;
        unread_next = unread_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        n_next      = n_reg;
        l_next      = l_reg;
        idx_next    = idx_reg;
        w_next      = w_reg;
        k_next      = k_reg;
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        found_next  = found_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        w1v_next    = w1v_reg;
        w1a_next    = w1a_reg;
        w1d_next    = w1d_reg;
        w2v_next    = w2v_reg;
        w2a_next    = w2a_reg;
        w2d_next    = w2d_reg;
        ntot_next   = ntot_reg;
        nunr_next   = nunr_reg;
        st_next     = st_reg;
        res_next    = res_reg;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_raddr   = '0;

        if (cfg_we && cfg_index == REG_LOW)
        begin
            low_next = cfg_data;
        end
        if (cfg_we && cfg_index == REG_HIGH)
        begin
            high_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = cmd.opcode;
                    n_next    = cmd.article;
                    l_next    = cmd.range_end;
                    idx_next  = '0;
                    w_next    = '0;
                    sum_next  = '0;
                    w1v_next  = 1'b0;
                    w2v_next  = 1'b0;
                    ntot_next = total_reg;
                    nunr_next = unread_reg;
                    st_next   = ST_DONE;
                    unique case (cmd.opcode)
                        OP_READ, OP_UNREAD:
                        begin
                            state_next = S_SRD;
                        end
                        OP_APPEND:
                        begin
                            if (cmd.article > cmd.range_end)
                            begin
                                st_next    = ST_BAD;
                                state_next = S_FIN;
                            end
                            else if (total_reg == '0)
                            begin
                                w1v_next   = 1'b1;
                                w1a_next   = '0;
                                w1d_next   = '{s: cmd.article, e: cmd.range_end};
                                ntot_next  = total_reg + 1'b1;
                                nunr_next  = unread_reg + ({1'b0, cmd.range_end}
                                             - {1'b0, cmd.article} + 32'd1);
                                state_next = S_W1;
                            end
                            else
                            begin
                                idx_next   = total_reg - 1'b1;
                                state_next = S_SRD;
                            end
                        end
                        default:
                        begin
                            state_next = S_TRD;
                        end
                    endcase
                end
            end
            S_SRD:
            begin
                if (idx_reg == total_reg)
                begin
                    found_next = 1'b0;
                    state_next = S_DEC;
                end
                else
                begin
                    ram_raddr  = idx_reg[AW-1:0];
                    state_next = S_SEV;
                end
            end
            S_SEV:
            begin
                cur_next = ram_rdata;
                if (op_reg == OP_APPEND || ram_rdata.e >= n_reg)
                begin
                    found_next = 1'b1;
                    state_next = S_DEC;
                end
                else
                begin
                    prev_next  = ram_rdata;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SRD;
                end
            end
            S_DEC:
            begin
                state_next = S_W1;
                if (op_reg == OP_APPEND)
                begin
                    if (n_reg <= cur_reg.e)
                    begin
                        st_next    = ST_BAD;
                        state_next = S_FIN;
                    end
                    else if (cur_inc == n_ext)
                    begin
                        w1v_next  = 1'b1;
                        w1a_next  = idx_reg[AW-1:0];
                        w1d_next  = '{s: cur_reg.s, e: l_reg};
                        nunr_next = unread_reg + span;
                    end
                    else if (total_reg >= CW'(MAX_RANGES))
                    begin
                        st_next    = ST_FULL;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        w1v_next  = 1'b1;
                        w1a_next  = total_reg[AW-1:0];
                        w1d_next  = '{s: n_reg, e: l_reg};
                        ntot_next = total_reg + 1'b1;
                        nunr_next = unread_reg + span;
                    end
                end
                else if (op_reg == OP_READ)
                begin
                    nunr_next = unread_reg - 32'd1;
                    if (!found_reg || cur_reg.s > n_reg)
                    begin
                        st_next    = ST_SAME;
                        state_next = S_FIN;
                    end
                    else if (cur_reg.s == cur_reg.e)
                    begin
                        ntot_next  = total_reg - 1'b1;
                        k_next     = idx_reg;
                        state_next = S_DNR;
                    end
                    else if (n_reg == cur_reg.s)
                    begin
                        w1v_next = 1'b1;
                        w1a_next = idx_reg[AW-1:0];
                        w1d_next = '{s: n_inc[NB-1:0], e: cur_reg.e};
                    end
                    else if (n_reg == cur_reg.e)
                    begin
                        w1v_next = 1'b1;
                        w1a_next = idx_reg[AW-1:0];
                        w1d_next = '{s: cur_reg.s, e: n_reg - 1'b1};
                    end
                    else if (total_reg >= CW'(MAX_RANGES))
                    begin
                        st_next    = ST_FULL;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ntot_next  = total_reg + 1'b1;
                        k_next     = total_reg;
                        pos_next   = idx_reg + 1'b1;
                        w1v_next   = 1'b1;
                        w1a_next   = AW'(idx_reg + 1'b1);
                        w1d_next   = '{s: n_inc[NB-1:0], e: cur_reg.e};
                        w2v_next   = 1'b1;
                        w2a_next   = idx_reg[AW-1:0];
                        w2d_next   = '{s: cur_reg.s, e: n_reg - 1'b1};
                        state_next = S_UPR;
                    end
                end
                else
                begin
                    nunr_next = unread_reg + 32'd1;
                    if (found_reg && cur_reg.s <= n_reg)
                    begin
                        st_next    = ST_SAME;
                        state_next = S_FIN;
                    end
                    else if (left && right)
                    begin
                        w1v_next   = 1'b1;
                        w1a_next   = AW'(idx_reg - 1'b1);
                        w1d_next   = '{s: prev_reg.s, e: cur_reg.e};
                        ntot_next  = total_reg - 1'b1;
                        k_next     = idx_reg;
                        state_next = S_DNR;
                    end
                    else if (left)
                    begin
                        w1v_next = 1'b1;
                        w1a_next = AW'(idx_reg - 1'b1);
                        w1d_next = '{s: prev_reg.s, e: n_reg};
                    end
                    else if (right)
                    begin
                        w1v_next = 1'b1;
                        w1a_next = idx_reg[AW-1:0];
                        w1d_next = '{s: n_reg, e: cur_reg.e};
                    end
                    else if (total_reg >= CW'(MAX_RANGES))
                    begin
                        st_next    = ST_FULL;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ntot_next  = total_reg + 1'b1;
                        k_next     = total_reg;
                        pos_next   = idx_reg;
                        w1v_next   = 1'b1;
                        w1a_next   = idx_reg[AW-1:0];
                        w1d_next   = '{s: n_reg, e: n_reg};
                        state_next = S_UPR;
                    end
                end
            end
            S_UPR:
            begin
                if (k_reg == pos_reg)
                begin
                    state_next = S_W1;
                end
                else
                begin
                    ram_raddr  = AW'(k_reg - 1'b1);
                    state_next = S_UPW;
                end
            end
            S_UPW:
            begin
                ram_we     = 1'b1;
                ram_waddr  = k_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                k_next     = k_reg - 1'b1;
                state_next = S_UPR;
            end
            S_DNR:
            begin
                if ({1'b0, k_reg} + 8'd1 >= {1'b0, total_reg})
                begin
                    state_next = S_W1;
                end
                else
                begin
                    ram_raddr  = AW'(k_reg + 1'b1);
                    state_next = S_DNW;
                end
            end
            S_DNW:
            begin
                ram_we     = 1'b1;
                ram_waddr  = k_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                k_next     = k_reg + 1'b1;
                state_next = S_DNR;
            end
            S_W1:
            begin
                ram_we     = w1v_reg;
                ram_waddr  = w1a_reg;
                ram_wdata  = w1d_reg;
                state_next = S_W2;
            end
            S_W2:
            begin
                ram_we     = w2v_reg;
                ram_waddr  = w2a_reg;
                ram_wdata  = w2d_reg;
                state_next = S_FIN;
            end
            S_TRD:
            begin
                if (idx_reg == total_reg)
                begin
                    ntot_next  = w_reg;
                    nunr_next  = sum_reg;
                    state_next = S_FIN;
                end
                else
                begin
                    ram_raddr  = idx_reg[AW-1:0];
                    state_next = S_TEV;
                end
            end
            S_TEV:
            begin
                if (clip.s <= clip.e)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = w_reg[AW-1:0];
                    ram_wdata = clip;
                    w_next    = w_reg + 1'b1;
                    sum_next  = sum_reg + ({1'b0, clip.e} - {1'b0, clip.s} + 32'd1);
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_TRD;
            end
            S_FIN:
            begin
                if (st_reg == ST_DONE)
                begin
                    total_next  = ntot_reg;
                    unread_next = nunr_reg;
                    res_next    = '{status: st_reg, unread_count: nunr_reg,
                                    ranges_used: ntot_reg};
                end
                else
                begin
                    res_next    = '{status: st_reg, unread_count: unread_reg,
                                    ranges_used: total_reg};
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            low_reg    <= '0;
            high_reg   <= '0;
            total_reg  <= '0;
            unread_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            low_reg    <= low_next;
            high_reg   <= high_next;
            total_reg  <= total_next;
            unread_reg <= unread_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        n_reg     <= n_next;
        l_reg     <= l_next;
        idx_reg   <= idx_next;
        w_reg     <= w_next;
        k_reg     <= k_next;
        pos_reg   <= pos_next;
        sum_reg   <= sum_next;
        found_reg <= found_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        w1v_reg   <= w1v_next;
        w1a_reg   <= w1a_next;
        w1d_reg   <= w1d_next;
        w2v_reg   <= w2v_next;
        w2a_reg   <= w2a_next;
        w2d_reg   <= w2d_next;
        ntot_reg  <= ntot_next;
        nunr_reg  <= nunr_next;
        st_reg    <= st_next;
        res_reg   <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;
endmodule
`default_nettype wire

### hdl/urs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module urs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hdl/urs_chk.sv
// Port-level checker for unread_range_set, bound to the top level.
// Depends on urs_pkg and unread_range_set_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "unread_range_set_macros.svh"
module urs_chk (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              done,
    input wire urs_pkg::urs_out_t result
);
    import urs_pkg::*;

    `URS_ASSERT_NOW(a_done_idle, done, !busy)
    `URS_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    `URS_ASSERT_NOW(a_used_max, done, result.ranges_used <= CW'(MAX_RANGES))
    `URS_ASSERT_NEXT(a_done_pulse, done, !done)
endmodule

bind unread_range_set urs_chk u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
`default_nettype wire

### sim/urs_checker.sv
// Checker for the unread range set: predicts each result from accepted commands.
// Depends on urs_pkg; counts mismatches for the testbench top.
`timescale 1ns / 1ps
`default_nettype none
module urs_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire urs_pkg::urs_in_t  cmd,
    input  wire logic              done,
    input  wire urs_pkg::urs_out_t result,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [urs_pkg::NB-1:0] cfg_data,
    output int                     errors,
    output int                     pending
);
    import urs_pkg::*;

    logic [NB-1:0] starts [MAX_RANGES];
    logic [NB-1:0] ends [MAX_RANGES];
    int            held;
    logic [31:0]   total;
    logic [NB-1:0] lo_bound, hi_bound;
    urs_out_t      results_due[$];

    function automatic void insert_at(input int pos, input logic [NB-1:0] s,
                                      input logic [NB-1:0] e);
        for (int k = held; k > pos; k--)
        begin
            starts[k] = starts[k-1];
            ends[k] = ends[k-1];
        end
        starts[pos] = s;
        ends[pos] = e;
        held++;
    endfunction

    function automatic void remove_at(input int pos);
        for (int k = pos; k + 1 < held; k++)
        begin
            starts[k] = starts[k+1];
            ends[k] = ends[k+1];
        end
        held--;
    endfunction

    function automatic logic [1:0] mark_read(input logic [NB-1:0] n);
        int i;
        i = 0;
        while (i < held && !(starts[i] <= n && n <= ends[i])) i++;
        if (i >= held) return ST_SAME;
        if (starts[i] == ends[i]) remove_at(i);
        else if (n == starts[i]) starts[i] = n + 1'b1;
        else if (n == ends[i]) ends[i] = n - 1'b1;
        else
        begin
            if (held >= MAX_RANGES) return ST_FULL;
            insert_at(i + 1, n + 1'b1, ends[i]);
            ends[i] = n - 1'b1;
        end
        total--;
        return ST_DONE;
    endfunction

    function automatic logic [1:0] mark_unread(input logic [NB-1:0] n);
        int i;
        bit left, right;
        i = 0;
        while (i < held && ends[i] < n) i++;
        if (i < held && starts[i] <= n) return ST_SAME;
        left = (i > 0) && ({1'b0, ends[i-1]} + 1 == {1'b0, n});
        right = (i < held) && ({1'b0, starts[i]} == {1'b0, n} + 1);
        if (left && right)
        begin
            ends[i-1] = ends[i];
            remove_at(i);
        end
        else if (left) ends[i-1] = n;
        else if (right) starts[i] = n;
        else
        begin
            if (held >= MAX_RANGES) return ST_FULL;
            insert_at(i, n, n);
        end
        total++;
        return ST_DONE;
    endfunction

    function automatic logic [1:0] append_range(input logic [NB-1:0] f, input logic [NB-1:0] l);
        if (f > l) return ST_BAD;
        if (held > 0)
        begin
            if (f <= ends[held-1]) return ST_BAD;
            if ({1'b0, ends[held-1]} + 1 == {1'b0, f})
            begin
                ends[held-1] = l;
                total += 32'(l - f) + 1;
                return ST_DONE;
            end
        end
        if (held >= MAX_RANGES) return ST_FULL;
        insert_at(held, f, l);
        total += 32'(l - f) + 1;
        return ST_DONE;
    endfunction

    function automatic logic [1:0] trim_set();
        int w;
        logic [NB-1:0] s, e;
        logic [31:0] sum;
        w = 0;
        sum = 0;
        for (int i = 0; i < held; i++)
        begin
            s = (starts[i] < lo_bound) ? lo_bound : starts[i];
            e = (ends[i] > hi_bound) ? hi_bound : ends[i];
            if (s <= e)
            begin
                starts[w] = s;
                ends[w] = e;
                sum += 32'(e - s) + 1;
                w++;
            end
        end
        held = w;
        total = sum;
        return ST_DONE;
    endfunction

    assign pending = results_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        urs_out_t want;
        logic [1:0] st;
        if (!rst_n)
        begin
            held = 0;
            total = 0;
            lo_bound = '0;
            hi_bound = '0;
            errors = 0;
            results_due.delete();
        end
        else
        begin
            if (done)
            begin
                if (results_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %h", result);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (result.status !== want.status
                        || result.unread_count !== want.unread_count
                        || result.ranges_used !== want.ranges_used)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: status %0d/%0d count %0d/%0d ranges %0d/%0d",
                                     want.status, result.status, want.unread_count,
                                     result.unread_count, want.ranges_used, result.ranges_used);
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_LOW) lo_bound = cfg_data;
                else if (cfg_index == REG_HIGH) hi_bound = cfg_data;
            end
            if (start && !busy)
            begin
                case (cmd.opcode)
                    OP_READ:   st = mark_read(cmd.article);
                    OP_UNREAD: st = mark_unread(cmd.article);
                    OP_APPEND: st = append_range(cmd.article, cmd.range_end);
                    default:   st = trim_set();
                endcase
                want.status = st;
                want.unread_count = total;
                want.ranges_used = CW'(held);
                results_due.push_back(want);
            end
        end
    end
endmodule
`default_nettype wire

### sim/unread_range_set_tb.sv
// Testbench top for the unread range set: command stimulus, bounds writes, verdict.
// Depends on urs_pkg, unread_range_set and urs_checker.
`timescale 1ns / 1ps
`default_nettype none
module unread_range_set_tb;
    import urs_pkg::*;

    localparam int WATCHDOG = 5000;
    localparam logic [NB-1:0] TOP = '1;
    localparam logic [1:0] REG_SPARE = 2'd2;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    urs_in_t       cmd = '0;
    logic          done;
    urs_out_t      result;
    logic          cfg_we = 1'b0;
    logic [1:0]    cfg_index = '0;
    logic [NB-1:0] cfg_data = '0;
    int            errors, pending;
    int            quiet_cycles = 0;
    int            gap_pct = 0;
    logic [NB-1:0] base = '0;
    logic [NB-1:0] tail = '0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    unread_range_set uut (.*);

    urs_checker checker_i (.*);

    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("unread_range_set_tb NOT OK");
            $finish;
        end
    end

    task automatic send(input logic [1:0] op, input logic [NB-1:0] a, input logic [NB-1:0] b);
        while ($urandom_range(99) < gap_pct) @(posedge clk);
        start <= 1'b1;
        cmd <= '{opcode: op, article: a, range_end: b};
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_bound(input logic [1:0] idx, input logic [NB-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly numbers close to the current base so ranges meet and split.
    function automatic logic [NB-1:0] near();
        return ($urandom_range(9) == 0) ? NB'($urandom) : base + NB'($urandom_range(200));
    endfunction

    task automatic random_ops(input int count);
        logic [NB-1:0] a, len;
        int r;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(99);
            if (r < 38) send(OP_UNREAD, near(), NB'($urandom));
            else if (r < 74) send(OP_READ, near(), NB'($urandom));
            else if (r < 94)
            begin
                len = NB'($urandom_range(5));
                if ($urandom_range(9) == 0)
                begin
                    a = NB'($urandom);
                    send(OP_APPEND, a, NB'($urandom));
                end
                else
                begin
                    a = tail + NB'($urandom_range(2));
                    send(OP_APPEND, a, a + len);
                    if (checker_i.held > 0) tail = checker_i.ends[checker_i.held-1] + 1'b1;
                end
            end
            else send(OP_TRIM, NB'($urandom), NB'($urandom));
            if (checker_i.held > 0) tail = checker_i.ends[checker_i.held-1] + 1'b1;
            else tail = base;
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, joins, splits, bad appends, unknown register
        send(OP_READ, '0, '0);
        send(OP_UNREAD, '0, '0);
        send(OP_UNREAD, '0, '0);
        send(OP_UNREAD, NB'(2), '0);
        send(OP_UNREAD, NB'(1), '0);
        send(OP_READ, NB'(1), '0);
        send(OP_READ, '0, '0);
        send(OP_APPEND, NB'(10), NB'(5));
        send(OP_APPEND, NB'(2), NB'(4));
        send(OP_APPEND, NB'(3), NB'(9));
        send(OP_APPEND, NB'(12), NB'(20));
        send(OP_APPEND, NB'(21), TOP - 1'b1);
        send(OP_UNREAD, TOP, TOP);
        send(OP_READ, NB'(15), '0);
        send(OP_READ, TOP, '0);
        send(OP_UNREAD, NB'(11), '0);
        drain();
        set_bound(REG_LOW, NB'(5));
        set_bound(REG_HIGH, TOP);
        set_bound(REG_SPARE, NB'(7));
        send(OP_TRIM, '0, '0);
        drain();
        set_bound(REG_LOW, NB'(9));
        set_bound(REG_HIGH, NB'(3));
        send(OP_TRIM, '0, '0);
        drain();
        // fill the table to test the full cases
        for (int k = 0; k < MAX_RANGES; k++) send(OP_APPEND, NB'(4 * k + 100), NB'(4 * k + 101));
        send(OP_APPEND, NB'(1000), NB'(1001));
        send(OP_READ, NB'(100 + 4 * 5), '0);
        send(OP_READ, NB'(100), '0);
        send(OP_READ, NB'(100), '0);
        send(OP_UNREAD, NB'(106), '0);
        send(OP_UNREAD, NB'(50), '0);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            gap_pct = (phase % 4 == 1) ? 66 : (phase % 4 == 3) ? 18 : 0;
            base = (phase == 4) ? TOP - NB'(300) : NB'($urandom_range(1000000));
            case (phase % 3)
                0: begin set_bound(REG_LOW, '0); set_bound(REG_HIGH, TOP); end
                1: begin set_bound(REG_LOW, base + NB'(40)); set_bound(REG_HIGH, base + NB'(160)); end
                default: begin set_bound(REG_LOW, TOP); set_bound(REG_HIGH, '0); end
            endcase
            send(OP_TRIM, '0, '0);
            drain();
            set_bound(REG_LOW, base + NB'(60));
            set_bound(REG_HIGH, base + NB'($urandom_range(400)));
            tail = base;
            random_ops(220);
            drain();
        end

        if (errors == 0) $display("unread_range_set_tb OK");
        else $display("unread_range_set_tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
